>>> hdl/msp_pkg.sv
// msp_pkg: shared types and constants for the moving sphere versus plane test
// no dependencies; used by msp_div and moving_sphere_plane_test
package msp_pkg;

  localparam int T_W    = 16;
  localparam int DEN_W  = 32;
  localparam int CFG_W  = 32;
  localparam int NRM_W  = 18;
  localparam int CRD_W  = 32;
  localparam int RAD_W  = 31;

  typedef enum logic [2:0] {
    CFG_NORMAL_X = 3'd0,
    CFG_NORMAL_Y = 3'd1,
    CFG_NORMAL_Z = 3'd2,
    CFG_PLANE_X  = 3'd3,
    CFG_PLANE_Y  = 3'd4,
    CFG_PLANE_Z  = 3'd5
  } cfg_idx_t;

  localparam logic signed [NRM_W-1:0] NORMAL_X_RST = 18'sh00000;
  localparam logic signed [NRM_W-1:0] NORMAL_Y_RST = 18'sh10000;
  localparam logic signed [NRM_W-1:0] NORMAL_Z_RST = 18'sh00000;

  // sideband that travels alongside the divider
  typedef struct packed {
    logic                     vld;
    logic                     touch;
    logic                     sweep;
    logic [2:0][CRD_W-1:0]    c0;
    logic [2:0][CRD_W:0]      dc;
  } msp_side_t;

endpackage

>>> hdl/msp_div.sv
// msp_div: pipelined restoring divider, one quotient bit per stage
// gives floor(num * 2^16 / den) for num < den; depends on msp_pkg
module msp_div import msp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DEN_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  msp_side_t        side_in,
  output logic [T_W-1:0]   quot,
  output msp_side_t        side_out
);

  logic [DEN_W-1:0] rem_r  [T_W];
  logic [DEN_W-1:0] den_r  [T_W];
  logic [T_W-1:0]   quot_r [T_W];
  msp_side_t        side_r [T_W];

  for (genvar k = 0; k < T_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [T_W-1:0]   quot_in;
    msp_side_t        side_pre;
    logic [DEN_W:0]   rem2;
    logic             ge;
    logic [DEN_W-1:0] rem_nxt;
    logic [T_W-1:0]   quot_nxt;

    if (k == 0) begin : g_first
      assign rem_in   = num;
      assign den_in   = den;
      assign quot_in  = '0;
      assign side_pre = side_in;
    end else begin : g_rest
      assign rem_in   = rem_r[k-1];
      assign den_in   = den_r[k-1];
      assign quot_in  = quot_r[k-1];
      assign side_pre = side_r[k-1];
    end

    always_comb begin
      rem2     = {rem_in, 1'b0};
      ge       = (rem2 >= {1'b0, den_in});
      rem_nxt  = ge ? DEN_W'(rem2 - {1'b0, den_in}) : rem2[DEN_W-1:0];
      quot_nxt = {quot_in[T_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].vld <= 1'b0;
      end else if (en) begin
        side_r[k].vld <= side_pre.vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]          <= rem_nxt;
        den_r[k]          <= den_in;
        quot_r[k]         <= quot_nxt;
        side_r[k].touch   <= side_pre.touch;
        side_r[k].sweep   <= side_pre.sweep;
        side_r[k].c0      <= side_pre.c0;
        side_r[k].dc      <= side_pre.dc;
      end
    end
  end

  assign quot     = quot_r[T_W-1];
  assign side_out = side_r[T_W-1];

endmodule

>>> hdl/moving_sphere_plane_test.sv
// moving_sphere_plane_test: fixed-point moving sphere versus plane test
// one transfer per cycle sustained unless out_stall holds the pipe
// every stage advances together; the whole pipe holds while out_valid && out_stall
// 16 of the stages are the quotient pipeline for t, one bit a stage
// synchronous active-low reset clears valid bits and loads the unit-y normal and origin
// depends on msp_pkg and msp_div
module moving_sphere_plane_test import msp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_idx,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CRD_W-1:0] in_start_x,
  input  logic signed [CRD_W-1:0] in_start_y,
  input  logic signed [CRD_W-1:0] in_start_z,
  input  logic signed [CRD_W-1:0] in_end_x,
  input  logic signed [CRD_W-1:0] in_end_y,
  input  logic signed [CRD_W-1:0] in_end_z,
  input  logic [RAD_W-1:0]        in_radius,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_hit,
  output logic signed [CRD_W-1:0] out_contact_x,
  output logic signed [CRD_W-1:0] out_contact_y,
  output logic signed [CRD_W-1:0] out_contact_z
);

  function automatic logic signed [CRD_W-1:0] sat_dist(input logic signed [52:0] s);
    logic signed [36:0] f;
    f = s[52:16];
    if (f[36:31] == '0 || f[36:31] == '1) begin
      return f[31:0];
    end else if (f[36]) begin
      return {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(CRD_W-1){1'b1}}};
    end
  endfunction

  // configuration
  logic signed [NRM_W-1:0] normal_r [3];
  logic signed [CRD_W-1:0] plane_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r[0] <= NORMAL_X_RST;
      normal_r[1] <= NORMAL_Y_RST;
      normal_r[2] <= NORMAL_Z_RST;
      plane_r[0]  <= '0;
      plane_r[1]  <= '0;
      plane_r[2]  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_NORMAL_X: normal_r[0] <= cfg_data[NRM_W-1:0];
        CFG_NORMAL_Y: normal_r[1] <= cfg_data[NRM_W-1:0];
        CFG_NORMAL_Z: normal_r[2] <= cfg_data[NRM_W-1:0];
        CFG_PLANE_X:  plane_r[0]  <= cfg_data;
        CFG_PLANE_Y:  plane_r[1]  <= cfg_data;
        CFG_PLANE_Z:  plane_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic signed [CRD_W-1:0] c0_in [3];
  logic signed [CRD_W-1:0] c1_in [3];
  assign c0_in[0] = in_start_x;
  assign c0_in[1] = in_start_y;
  assign c0_in[2] = in_start_z;
  assign c1_in[0] = in_end_x;
  assign c1_in[1] = in_end_y;
  assign c1_in[2] = in_end_z;

  // stage 1: offsets from the plane point and motion delta
  logic signed [CRD_W:0]   p0_r [3];
  logic signed [CRD_W:0]   p1_r [3];
  logic signed [CRD_W:0]   p0_nxt [3];
  logic signed [CRD_W:0]   p1_nxt [3];
  msp_side_t               side1_r, side1_nxt;
  logic [RAD_W-1:0]        rad1_r;

  always_comb begin
    side1_nxt       = '0;
    side1_nxt.vld   = in_valid;
    for (int i = 0; i < 3; i++) begin
      p0_nxt[i]        = {c0_in[i][CRD_W-1], c0_in[i]} - {plane_r[i][CRD_W-1], plane_r[i]};
      p1_nxt[i]        = {c1_in[i][CRD_W-1], c1_in[i]} - {plane_r[i][CRD_W-1], plane_r[i]};
      side1_nxt.c0[i]  = c0_in[i];
      side1_nxt.dc[i]  = {c1_in[i][CRD_W-1], c1_in[i]} - {c0_in[i][CRD_W-1], c0_in[i]};
    end
  end

  // stage 2: products with the normal
  logic signed [50:0] m0_r [3];
  logic signed [50:0] m1_r [3];
  logic signed [50:0] m0_nxt [3];
  logic signed [50:0] m1_nxt [3];
  msp_side_t          side2_r;
  logic [RAD_W-1:0]   rad2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m0_nxt[i] = $signed({{18{p0_r[i][CRD_W]}}, p0_r[i]})
                * $signed({{33{normal_r[i][NRM_W-1]}}, normal_r[i]});
      m1_nxt[i] = $signed({{18{p1_r[i][CRD_W]}}, p1_r[i]})
                * $signed({{33{normal_r[i][NRM_W-1]}}, normal_r[i]});
    end
  end

  // stage 3: dot product, floor to Q16.16, saturate
  logic signed [CRD_W-1:0] d0_r, d1_r, d0_nxt, d1_nxt;
  logic signed [52:0]      sum0, sum1;
  msp_side_t               side3_r;
  logic [RAD_W-1:0]        rad3_r;

  always_comb begin
    sum0 = {{2{m0_r[0][50]}}, m0_r[0]} + {{2{m0_r[1][50]}}, m0_r[1]}
         + {{2{m0_r[2][50]}}, m0_r[2]};
    sum1 = {{2{m1_r[0][50]}}, m1_r[0]} + {{2{m1_r[1][50]}}, m1_r[1]}
         + {{2{m1_r[2][50]}}, m1_r[2]};
    d0_nxt = sat_dist(sum0);
    d1_nxt = sat_dist(sum1);
  end

  // stage 4: classify and set up the divide
  logic signed [CRD_W:0] d0_e, d1_e, r_e, ad0, den_w;
  logic [DEN_W-1:0]      num_r, den_r, num_nxt, den_nxt;
  msp_side_t             side4_r, side4_nxt;

  always_comb begin
    d0_e  = {d0_r[CRD_W-1], d0_r};
    d1_e  = {d1_r[CRD_W-1], d1_r};
    r_e   = {2'b00, rad3_r};
    ad0   = d0_e[CRD_W] ? -d0_e : d0_e;
    den_w = d0_e - d1_e;
    side4_nxt       = side3_r;
    side4_nxt.touch = (ad0 <= r_e);
    side4_nxt.sweep = !(ad0 <= r_e) && (d0_e > r_e) && (d1_e < r_e);
    num_nxt         = DEN_W'(d0_e - r_e);
    den_nxt         = den_w[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.vld <= 1'b0;
      side2_r.vld <= 1'b0;
      side3_r.vld <= 1'b0;
      side4_r.vld <= 1'b0;
    end else if (en) begin
      side1_r.vld <= side1_nxt.vld;
      side2_r.vld <= side1_r.vld;
      side3_r.vld <= side2_r.vld;
      side4_r.vld <= side4_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      rad1_r  <= in_radius;
      side1_r.touch <= side1_nxt.touch;
      side1_r.sweep <= side1_nxt.sweep;
      side1_r.c0    <= side1_nxt.c0;
      side1_r.dc    <= side1_nxt.dc;

      m0_r    <= m0_nxt;
      m1_r    <= m1_nxt;
      rad2_r  <= rad1_r;
      side2_r.touch <= side1_r.touch;
      side2_r.sweep <= side1_r.sweep;
      side2_r.c0    <= side1_r.c0;
      side2_r.dc    <= side1_r.dc;

      d0_r    <= d0_nxt;
      d1_r    <= d1_nxt;
      rad3_r  <= rad2_r;
      side3_r.touch <= side2_r.touch;
      side3_r.sweep <= side2_r.sweep;
      side3_r.c0    <= side2_r.c0;
      side3_r.dc    <= side2_r.dc;

      num_r   <= num_nxt;
      den_r   <= den_nxt;
      side4_r.touch <= side4_nxt.touch;
      side4_r.sweep <= side4_nxt.sweep;
      side4_r.c0    <= side4_nxt.c0;
      side4_r.dc    <= side4_nxt.dc;
    end
  end

  // time of first contact
  logic [T_W-1:0] t_q;
  msp_side_t      side_d;

  msp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .num      (num_r),
    .den      (den_r),
    .side_in  (side4_r),
    .quot     (t_q),
    .side_out (side_d)
  );

  // stage 5: t times motion delta
  logic signed [49:0] off_r [3];
  logic signed [49:0] off_nxt [3];
  msp_side_t          side5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off_nxt[i] = $signed({{(50-T_W){1'b0}}, t_q})
                 * $signed({{(49-CRD_W){side_d.dc[i][CRD_W]}}, side_d.dc[i]});
    end
  end

  // stage 6: contact point into the output register
  logic                    hit_r, hit_nxt;
  logic signed [CRD_W-1:0] contact_r [3];
  logic signed [CRD_W-1:0] contact_nxt [3];
  logic                    out_valid_r;

  always_comb begin
    hit_nxt = side5_r.touch || side5_r.sweep;
    for (int i = 0; i < 3; i++) begin
      if (side5_r.touch) begin
        contact_nxt[i] = side5_r.c0[i];
      end else if (side5_r.sweep) begin
        contact_nxt[i] = side5_r.c0[i] + off_r[i][47:16];
      end else begin
        contact_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side5_r.vld <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      side5_r.vld <= side_d.vld;
      out_valid_r <= side5_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_r         <= off_nxt;
      side5_r.touch <= side_d.touch;
      side5_r.sweep <= side_d.sweep;
      side5_r.c0    <= side_d.c0;
      side5_r.dc    <= side_d.dc;
      hit_r         <= hit_nxt;
      contact_r     <= contact_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_contact_x = contact_r[0];
  assign out_contact_y = contact_r[1];
  assign out_contact_z = contact_r[2];

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |->
      out_contact_x == '0 && out_contact_y == '0 && out_contact_z == '0)
    else $error("miss result with non-zero contact");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    side4_r.vld && side4_r.sweep |-> num_r < den_r && num_r != '0)
    else $error("divider operands out of order");

  a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
    side4_r.vld |-> !(side4_r.touch && side4_r.sweep))
    else $error("touch and sweep both set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(side4_r) && $stable(num_r) && $stable(den_r))
    else $error("pipeline moved while held");
`endif

endmodule

>>> dv/tb_moving_sphere_plane_test.sv
`timescale 1ns / 1ps
// tb_moving_sphere_plane_test: self-checking bench for the moving sphere versus plane test
// predicts hit and contact centre for every sphere transfer and compares each result in order
// depends on msp_pkg and moving_sphere_plane_test
module tb_moving_sphere_plane_test;
  import msp_pkg::*;

  localparam int                      CYCLE_LIMIT = 500_000;
  localparam int                      DRAIN_WAIT  = 30;
  localparam logic signed [CRD_W-1:0] ONE         = 32'sd65536;
  localparam logic signed [CRD_W-1:0] Q_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [CRD_W-1:0] Q_MIN       = 32'sh8000_0000;
  localparam logic [RAD_W-1:0]        R_ONE       = 31'h0001_0000;
  localparam logic [RAD_W-1:0]        R_MAX       = 31'h7FFF_FFFF;
  localparam logic signed [NRM_W-1:0] NRM_MAX     = 18'sh1FFFF;
  localparam logic signed [NRM_W-1:0] NRM_MIN     = 18'sh20000;
  localparam logic signed [NRM_W-1:0] NRM_ONE     = 18'sh10000;
  localparam logic [2:0]              CFG_SPARE_6 = 3'd6;
  localparam logic [2:0]              CFG_SPARE_7 = 3'd7;
  localparam longint                  DIST_MAX    = 64'sd2147483647;
  localparam longint                  DIST_MIN    = -64'sd2147483648;

  typedef struct {
    logic signed [CRD_W-1:0] sx, sy, sz;
    logic signed [CRD_W-1:0] ex, ey, ez;
    logic [RAD_W-1:0]        r;
  } sphere_t;

  typedef struct {
    logic                    hit;
    logic signed [CRD_W-1:0] cx, cy, cz;
  } contact_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [2:0]              cfg_idx;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [CRD_W-1:0] in_start_x, in_start_y, in_start_z;
  logic signed [CRD_W-1:0] in_end_x, in_end_y, in_end_z;
  logic [RAD_W-1:0]        in_radius;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_hit;
  logic signed [CRD_W-1:0] out_contact_x, out_contact_y, out_contact_z;

  // shadow of the plane registers
  logic signed [NRM_W-1:0] nrm_x, nrm_y, nrm_z;
  logic signed [CRD_W-1:0] pnt_x, pnt_y, pnt_z;

  contact_t pending_contacts[$];
  bit       throttle = 1'b1;
  int       err_count;
  int       cycle_count;
  int       n_spheres, n_touch, n_sweep, n_miss, n_settings;

  moving_sphere_plane_test u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_start_z    (in_start_z),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_end_z      (in_end_z),
    .in_radius     (in_radius),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_contact_x (out_contact_x),
    .out_contact_y (out_contact_y),
    .out_contact_z (out_contact_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // signed distance of a centre from the plane, floored to Q16.16 and saturated
  function automatic longint plane_offset(longint cx, longint cy, longint cz);
    longint acc;
    acc = (cx - longint'(pnt_x)) * longint'(nrm_x)
        + (cy - longint'(pnt_y)) * longint'(nrm_y)
        + (cz - longint'(pnt_z)) * longint'(nrm_z);
    acc = acc >>> 16;
    if (acc > DIST_MAX) acc = DIST_MAX;
    else if (acc < DIST_MIN) acc = DIST_MIN;
    return acc;
  endfunction

  function automatic contact_t predict_contact(sphere_t s);
    longint   c0[3], c1[3], ci[3];
    longint   d0, d1, r, ad0, num, den, t;
    contact_t res;
    c0[0] = s.sx; c0[1] = s.sy; c0[2] = s.sz;
    c1[0] = s.ex; c1[1] = s.ey; c1[2] = s.ez;
    r     = longint'(s.r);
    d0    = plane_offset(c0[0], c0[1], c0[2]);
    d1    = plane_offset(c1[0], c1[1], c1[2]);
    ad0   = (d0 < 0) ? -d0 : d0;
    res.hit = 1'b0;
    for (int i = 0; i < 3; i++) ci[i] = 0;
    if (ad0 <= r) begin
      res.hit = 1'b1;
      for (int i = 0; i < 3; i++) ci[i] = c0[i];
      n_touch++;
    end else if (d0 > r && d1 < r) begin
      num = d0 - r;
      den = d0 - d1;
      t   = (num <<< 16) / den;
      res.hit = 1'b1;
      for (int i = 0; i < 3; i++) ci[i] = c0[i] + ((t * (c1[i] - c0[i])) >>> 16);
      n_sweep++;
    end else begin
      n_miss++;
    end
    res.cx = ci[0][CRD_W-1:0];
    res.cy = ci[1][CRD_W-1:0];
    res.cz = ci[2][CRD_W-1:0];
    return res;
  endfunction

  function automatic sphere_t make_sphere(logic signed [CRD_W-1:0] sx, sy, sz, ex, ey, ez,
                                          logic [RAD_W-1:0] r);
    sphere_t s;
    s.sx = sx; s.sy = sy; s.sz = sz;
    s.ex = ex; s.ey = ey; s.ez = ez;
    s.r  = r;
    return s;
  endfunction

  function automatic longint spread(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // mostly spheres near the plane moving roughly along the normal, some wild ones
  function automatic sphere_t draw_sphere();
    sphere_t s;
    longint  n[3], q[3], c0[3], c1[3];
    longint  span, lift, drop;
    int      kind;
    n[0] = nrm_x; n[1] = nrm_y; n[2] = nrm_z;
    q[0] = pnt_x; q[1] = pnt_y; q[2] = pnt_z;
    kind = $urandom_range(0, 7);
    span = longint'(1) << $urandom_range(4, 26);
    lift = spread(2 * span);
    drop = longint'($urandom_range(0, 32'(4 * span)));
    for (int i = 0; i < 3; i++) begin
      c0[i] = q[i] + spread(span) + ((n[i] * lift) >>> 16);
      c1[i] = c0[i] - ((n[i] * drop) >>> 16) + spread(span >>> 4);
    end
    if (kind < 5) begin
      s.r = ($urandom_range(0, 7) == 0) ? '0 : RAD_W'($urandom_range(0, 32'(span)));
    end else if (kind < 7) begin
      for (int i = 0; i < 3; i++) begin
        c0[i] = $urandom;
        c1[i] = $urandom;
      end
      s.r = RAD_W'($urandom);
    end else begin
      for (int i = 0; i < 3; i++) c1[i] = $urandom;
      s.r = RAD_W'($urandom >> $urandom_range(0, 31));
    end
    s.sx = c0[0][CRD_W-1:0]; s.sy = c0[1][CRD_W-1:0]; s.sz = c0[2][CRD_W-1:0];
    s.ex = c1[0][CRD_W-1:0]; s.ey = c1[1][CRD_W-1:0]; s.ez = c1[2][CRD_W-1:0];
    return s;
  endfunction

  task automatic send_sphere(input sphere_t s);
    int gap;
    if ($urandom_range(0, 39) == 0) throttle = !throttle;
    gap = throttle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_start_x <= s.sx;
    in_start_y <= s.sy;
    in_start_z <= s.sz;
    in_end_x   <= s.ex;
    in_end_y   <= s.ey;
    in_end_z   <= s.ez;
    in_radius  <= s.r;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_contacts.push_back(predict_contact(s));
    n_spheres++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_contacts.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_NORMAL_X: nrm_x = data[NRM_W-1:0];
      CFG_NORMAL_Y: nrm_y = data[NRM_W-1:0];
      CFG_NORMAL_Z: nrm_z = data[NRM_W-1:0];
      CFG_PLANE_X:  pnt_x = data;
      CFG_PLANE_Y:  pnt_y = data;
      CFG_PLANE_Z:  pnt_z = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // normals carry random junk above bit 17, which the block must drop
  task automatic set_plane(input logic signed [NRM_W-1:0] nx, ny, nz,
                           input logic signed [CRD_W-1:0] px, py, pz);
    logic [CFG_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_NORMAL_X, {junk[CFG_W-1:NRM_W], nx});
    junk = $urandom;
    write_reg(CFG_NORMAL_Y, {junk[CFG_W-1:NRM_W], ny});
    junk = $urandom;
    write_reg(CFG_NORMAL_Z, {junk[CFG_W-1:NRM_W], nz});
    write_reg(CFG_PLANE_X, px);
    write_reg(CFG_PLANE_Y, py);
    write_reg(CFG_PLANE_Z, pz);
    n_settings++;
  endtask

  task automatic test_reset_plane();
    send_sphere(make_sphere(0, 0, 0, 0, 0, 0, 0));
    send_sphere(make_sphere(3 * ONE, 10 * ONE, -2 * ONE, 7 * ONE, -10 * ONE, 5 * ONE, R_ONE));
    send_sphere(make_sphere(0, 10 * ONE, 0, 0, 5 * ONE, 0, R_ONE));
    send_sphere(make_sphere(0, -10 * ONE, 0, 0, 10 * ONE, 0, R_ONE));
    send_sphere(make_sphere(0, ONE, 0, 0, -ONE, 0, R_ONE));
    send_sphere(make_sphere(0, -ONE, 0, 0, 0, 0, R_ONE));
    send_sphere(make_sphere(0, ONE + 1, 0, 0, ONE, 0, R_ONE));
    send_sphere(make_sphere(0, ONE + 1, 0, 0, ONE - 1, 0, R_ONE));
    send_sphere(make_sphere(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0));
    send_sphere(make_sphere(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, R_MAX));
    send_sphere(make_sphere(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, R_MAX));
    send_sphere(make_sphere(-1, -1, -1, -1, -1, -1, 0));
  endtask

  task automatic test_tilted_planes();
    // facing -x through x = -5
    set_plane(-NRM_ONE, 0, 0, -5 * ONE, 0, 0);
    write_reg(CFG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_7, 32'h1234_5678);
    send_sphere(make_sphere(-10 * ONE, ONE, 2, 0, -ONE, 9, R_ONE << 1));
    send_sphere(make_sphere(-5 * ONE, 7, 7, 3 * ONE, 7, 7, 0));
    // oversized normal drives the distance into saturation
    set_plane(NRM_MAX, NRM_MAX, NRM_MAX, Q_MIN, Q_MIN, Q_MIN);
    send_sphere(make_sphere(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 5));
    send_sphere(make_sphere(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0));
    set_plane(NRM_MIN, NRM_MIN, NRM_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_sphere(make_sphere(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, R_MAX));
    send_sphere(make_sphere(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, R_MAX));
    // tiny normal shows the floor of negative distances
    set_plane(1, 0, 0, 0, Q_MAX, Q_MAX);
    send_sphere(make_sphere(3, 0, 0, -3, 0, 0, 0));
    send_sphere(make_sphere(-3, 0, 0, 3, 0, 0, 0));
    send_sphere(make_sphere(Q_MAX, 0, 0, Q_MIN, 0, 0, 0));
  endtask

  function automatic logic signed [NRM_W-1:0] extreme_normal();
    case ($urandom_range(0, 4))
      0:       return NRM_MIN;
      1:       return NRM_MAX;
      2:       return -NRM_ONE;
      3:       return NRM_ONE;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [CRD_W-1:0] extreme_point();
    case ($urandom_range(0, 2))
      0:       return Q_MIN;
      1:       return Q_MAX;
      default: return '0;
    endcase
  endfunction

  task automatic test_random_sweeps();
    logic signed [NRM_W-1:0] n[3];
    logic signed [CRD_W-1:0] q[3];
    int                      kind;
    for (int phase = 0; phase < 8; phase++) begin
      kind = (phase < 4) ? phase : $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        case (kind)
          0: begin
            n[i] = '0;
            q[i] = CRD_W'(spread(longint'(1) << 24));
          end
          1: begin
            n[i] = NRM_W'(spread(65536));
            q[i] = CRD_W'(spread(longint'(1) << 28));
          end
          2: begin
            n[i] = NRM_W'($urandom);
            q[i] = $urandom;
          end
          default: begin
            n[i] = extreme_normal();
            q[i] = extreme_point();
          end
        endcase
      end
      if (kind == 0) n[$urandom_range(0, 2)] = $urandom_range(0, 1) ? NRM_ONE : -NRM_ONE;
      set_plane(n[0], n[1], n[2], q[0], q[1], q[2]);
      if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                                          $urandom);
      repeat (130) send_sphere(draw_sphere());
    end
  endtask

  // result side back-pressure, drawn once per result
  initial begin : result_stall
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      hold = throttle ? $urandom_range(0, 11) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    contact_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_contacts.size() == 0) begin
        $error("result transfer with no sphere outstanding");
        err_count++;
      end else begin
        want = pending_contacts.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          err_count++;
        end
        if (out_contact_x !== want.cx) begin
          $error("contact_x: expected %0d, got %0d", want.cx, out_contact_x);
          err_count++;
        end
        if (out_contact_y !== want.cy) begin
          $error("contact_y: expected %0d, got %0d", want.cy, out_contact_y);
          err_count++;
        end
        if (out_contact_z !== want.cz) begin
          $error("contact_z: expected %0d, got %0d", want.cz, out_contact_z);
          err_count++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_start_z = '0;
    in_end_x   = '0;
    in_end_y   = '0;
    in_end_z   = '0;
    in_radius  = '0;
    nrm_x      = NORMAL_X_RST;
    nrm_y      = NORMAL_Y_RST;
    nrm_z      = NORMAL_Z_RST;
    pnt_x      = '0;
    pnt_y      = '0;
    pnt_z      = '0;
    n_settings = 1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_plane();
    test_tilted_planes();
    test_random_sweeps();
    drain_results();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("%0d spheres over %0d plane settings: %0d touching at start, %0d swept, %0d missed",
             n_spheres, n_settings, n_touch, n_sweep, n_miss);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/msp_pkg.sv
hdl/msp_div.sv
hdl/moving_sphere_plane_test.sv
dv/tb_moving_sphere_plane_test.sv
